FILE: rtl/ptps_pkg.sv
// ----------------------------------------------------------------------------
// ptps_pkg
// types and constants shared by the clock servo modules
// ----------------------------------------------------------------------------
`default_nettype none

package ptps_pkg;

    localparam int OFFSET_W  = 63;
    localparam int TIME_W    = 62;
    localparam int WORD_W    = 32;
    localparam int DIV_W     = 31;
    localparam int THRESH_W  = 62;
    localparam int INTEG_W   = 18;
    localparam int MAG_W     = 64;
    localparam int DVD_W     = 96;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 62;

    localparam int DIV_STEPS = DVD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0]   BASE_ADDEND_RST = 32'd0;
    localparam logic [WORD_W-1:0]   SCALE_MULT_RST  = 32'd0;
    localparam logic [DIV_W-1:0]    SCALE_DIV_RST   = 31'd1000000;
    localparam logic [THRESH_W-1:0] STEP_THRESH_RST = 62'd100000000;
    localparam logic [DIV_W-1:0]    NS_PER_SEC      = 31'd1000000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDEND = 2'd0,
        REG_SCALE_MULT  = 2'd1,
        REG_SCALE_DIV   = 2'd2,
        REG_STEP_THRESH = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP1,
        ST_PREP2,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP1,
        OP_PREP2,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_DIV
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ptps_in_if.sv
// ----------------------------------------------------------------------------
// ptps_in_if
// measurement channel: offset and current clock time
// ----------------------------------------------------------------------------
`default_nettype none

interface ptps_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ptps_pkg::OFFSET_W-1:0]   time_offset;
    logic        [ptps_pkg::TIME_W-1:0]     current_time_ns;

    modport source (output valid, output time_offset, output current_time_ns, input ready);
    modport sink   (input valid, input time_offset, input current_time_ns, output ready);
    modport mon    (input valid, input time_offset, input current_time_ns, input ready);
endinterface

`default_nettype wire

FILE: rtl/ptps_out_if.sv
// ----------------------------------------------------------------------------
// ptps_out_if
// update channel: step or slew word for the clock
// ----------------------------------------------------------------------------
`default_nettype none

interface ptps_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_step;
    logic [ptps_pkg::WORD_W-1:0]    addend_value;
    logic [ptps_pkg::WORD_W-1:0]    set_seconds;
    logic [ptps_pkg::WORD_W-1:0]    set_nanoseconds;

    modport source (output valid, output is_step, output addend_value,
                    output set_seconds, output set_nanoseconds, input ready);
    modport sink   (input valid, input is_step, input addend_value,
                    input set_seconds, input set_nanoseconds, output ready);
    modport mon    (input valid, input is_step, input addend_value,
                    input set_seconds, input set_nanoseconds, input ready);
endinterface

`default_nettype wire

FILE: rtl/ptps_ctrl.sv
// ----------------------------------------------------------------------------
// ptps_ctrl
// sequencer for one servo update and output word handshake
// ----------------------------------------------------------------------------
`default_nettype none

module ptps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire ptps_pkg::dp_stat_t stat,
    output ptps_pkg::dp_cmd_t       cmd
);

    ptps_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptps_pkg::ST_IDLE:  if (in_valid) state_next = ptps_pkg::ST_PREP1;
            ptps_pkg::ST_PREP1: state_next = ptps_pkg::ST_PREP2;
            ptps_pkg::ST_PREP2: state_next = ptps_pkg::ST_MUL0;
            ptps_pkg::ST_MUL0:  state_next = ptps_pkg::ST_MUL1;
            ptps_pkg::ST_MUL1:  state_next = ptps_pkg::ST_MUL2;
            ptps_pkg::ST_MUL2:  state_next = ptps_pkg::ST_DIV;
            ptps_pkg::ST_DIV:   if (stat.div_done) state_next = ptps_pkg::ST_DONE;
            ptps_pkg::ST_DONE:  if (out_free) state_next = ptps_pkg::ST_IDLE;
            default:            state_next = ptps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.op       = ptps_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ptps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = ptps_pkg::OP_LOAD;
            end
            ptps_pkg::ST_PREP1: cmd.op = ptps_pkg::OP_PREP1;
            ptps_pkg::ST_PREP2: cmd.op = ptps_pkg::OP_PREP2;
            ptps_pkg::ST_MUL0:  cmd.op = ptps_pkg::OP_MUL0;
            ptps_pkg::ST_MUL1:  cmd.op = ptps_pkg::OP_MUL1;
            ptps_pkg::ST_MUL2:  cmd.op = ptps_pkg::OP_MUL2;
            ptps_pkg::ST_DIV:   cmd.op = ptps_pkg::OP_DIV;
            ptps_pkg::ST_DONE:  cmd.load_out = out_free;
            default:            cmd.op = ptps_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

endmodule

`default_nettype wire

FILE: rtl/ptps_dp.sv
// ----------------------------------------------------------------------------
// ptps_dp
// servo datapath: config registers, pi terms, shared multiplier and divider
// ----------------------------------------------------------------------------
`default_nettype none

module ptps_dp #(
    parameter int KP_SHIFT         = 2,
    parameter int KI_SHIFT         = 7,
    parameter int INTEGRATOR_LIMIT = 100000
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [ptps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ptps_pkg::CFG_DAT_W-1:0]         cfg_data,
    input  wire logic signed [ptps_pkg::OFFSET_W-1:0]   time_offset,
    input  wire logic [ptps_pkg::TIME_W-1:0]            current_time_ns,
    input  wire ptps_pkg::dp_cmd_t                      cmd,
    output ptps_pkg::dp_stat_t                          stat,
    output logic                                        is_step,
    output logic [ptps_pkg::WORD_W-1:0]                 addend_value,
    output logic [ptps_pkg::WORD_W-1:0]                 set_seconds,
    output logic [ptps_pkg::WORD_W-1:0]                 set_nanoseconds
);

    localparam logic signed [63:0] LIM_POS = 64'(INTEGRATOR_LIMIT);
    localparam logic signed [63:0] LIM_NEG = -64'(INTEGRATOR_LIMIT);

    // configuration
    logic        [ptps_pkg::WORD_W-1:0]   base_reg;
    logic signed [ptps_pkg::WORD_W-1:0]   mult_reg;
    logic        [ptps_pkg::DIV_W-1:0]    sdiv_reg;
    logic        [ptps_pkg::THRESH_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ptps_pkg::BASE_ADDEND_RST;
            mult_reg <= ptps_pkg::SCALE_MULT_RST;
            sdiv_reg <= ptps_pkg::SCALE_DIV_RST;
            thr_reg  <= ptps_pkg::STEP_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (ptps_pkg::cfg_idx_t'(cfg_index))
                ptps_pkg::REG_BASE_ADDEND: base_reg <= cfg_data[ptps_pkg::WORD_W-1:0];
                ptps_pkg::REG_SCALE_MULT:  mult_reg <= cfg_data[ptps_pkg::WORD_W-1:0];
                ptps_pkg::REG_SCALE_DIV:   sdiv_reg <= cfg_data[ptps_pkg::DIV_W-1:0];
                ptps_pkg::REG_STEP_THRESH: thr_reg  <= cfg_data[ptps_pkg::THRESH_W-1:0];
                default:                   base_reg <= base_reg;
            endcase
        end
    end

    // integrator
    logic signed [ptps_pkg::INTEG_W-1:0] integ_reg, integ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else
            integ_reg <= integ_next;
    end

    // working registers
    logic signed [ptps_pkg::OFFSET_W-1:0] off_reg;
    logic        [ptps_pkg::TIME_W-1:0]   now_reg;
    logic                                 step_reg;
    logic signed [ptps_pkg::INTEG_W-1:0]  acc_reg;
    logic signed [63:0]                   ch_reg;
    logic        [ptps_pkg::MAG_W-1:0]    mag_reg;
    logic                                 neg_reg;
    logic        [ptps_pkg::WORD_W-1:0]   mm_reg;
    logic        [ptps_pkg::DIV_W-1:0]    dv_reg;
    logic        [63:0]                   pl_reg;
    logic        [63:0]                   ph_reg;
    logic        [ptps_pkg::DVD_W-1:0]    dvd_reg;
    logic        [ptps_pkg::DIV_W-1:0]    rem_reg;
    logic        [ptps_pkg::WORD_W-1:0]   quo_reg;
    logic        [ptps_pkg::CNT_W-1:0]    cnt_reg;

    // pi terms
    logic        [ptps_pkg::OFFSET_W-1:0] mag_off;
    logic signed [63:0]                   acc_w;
    logic signed [63:0]                   acc_c;
    logic signed [63:0]                   total;
    logic signed [63:0]                   ch_w;
    logic        [ptps_pkg::WORD_W-1:0]   mult_mag;
    logic        [ptps_pkg::DIV_W-1:0]    dv_sel;

    assign mag_off  = off_reg[ptps_pkg::OFFSET_W-1] ? ptps_pkg::OFFSET_W'(-off_reg)
                                                    : ptps_pkg::OFFSET_W'(off_reg);
    assign acc_w    = 64'(integ_reg) + 64'(off_reg >>> KI_SHIFT);
    assign acc_c    = (acc_w > LIM_POS) ? LIM_POS : ((acc_w < LIM_NEG) ? LIM_NEG : acc_w);
    assign ch_w     = $signed({2'b00, now_reg}) + 64'(off_reg);
    assign total    = 64'(off_reg >>> KP_SHIFT) + 64'(acc_reg);
    assign mult_mag = mult_reg[ptps_pkg::WORD_W-1] ? ptps_pkg::WORD_W'(-mult_reg)
                                                   : ptps_pkg::WORD_W'(mult_reg);
    assign dv_sel   = (sdiv_reg == '0) ? ptps_pkg::DIV_W'(1) : sdiv_reg;

    // shared multiplier
    logic [ptps_pkg::WORD_W-1:0] mul_a;
    logic [63:0]                 prod;

    assign mul_a = (cmd.op == ptps_pkg::OP_MUL1) ? mag_reg[63:32] : mag_reg[31:0];
    assign prod  = mul_a * mm_reg;

    // radix-4 restoring divider step
    logic [ptps_pkg::WORD_W-1:0] r1, r2;
    logic [ptps_pkg::DIV_W-1:0]  rem1, rem2;
    logic                        qb1, qb2;

    always_comb
    begin
        r1   = {rem_reg, dvd_reg[ptps_pkg::DVD_W-1]};
        qb1  = (r1 >= {1'b0, dv_reg});
        rem1 = qb1 ? ptps_pkg::DIV_W'(r1 - {1'b0, dv_reg}) : r1[ptps_pkg::DIV_W-1:0];
        r2   = {rem1, dvd_reg[ptps_pkg::DVD_W-2]};
        qb2  = (r2 >= {1'b0, dv_reg});
        rem2 = qb2 ? ptps_pkg::DIV_W'(r2 - {1'b0, dv_reg}) : r2[ptps_pkg::DIV_W-1:0];
    end

    assign stat.div_done = (cnt_reg == ptps_pkg::CNT_W'(ptps_pkg::DIV_STEPS - 1));

    always_comb
    begin
        integ_next = integ_reg;
        if (cmd.op == ptps_pkg::OP_PREP2)
            integ_next = step_reg ? '0 : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ptps_pkg::OP_LOAD:
            begin
                off_reg <= time_offset;
                now_reg <= current_time_ns;
            end
            ptps_pkg::OP_PREP1:
            begin
                step_reg <= (mag_off > {1'b0, thr_reg});
                acc_reg  <= ptps_pkg::INTEG_W'(acc_c);
                ch_reg   <= ch_w;
            end
            ptps_pkg::OP_PREP2:
            begin
                if (step_reg)
                begin
                    mag_reg <= ch_reg[63] ? 64'(-ch_reg) : 64'(ch_reg);
                    neg_reg <= ch_reg[63];
                    mm_reg  <= ptps_pkg::WORD_W'(1);
                    dv_reg  <= ptps_pkg::NS_PER_SEC;
                end
                else
                begin
                    mag_reg <= total[63] ? 64'(-total) : 64'(total);
                    neg_reg <= total[63] ^ mult_reg[ptps_pkg::WORD_W-1];
                    mm_reg  <= mult_mag;
                    dv_reg  <= dv_sel;
                end
            end
            ptps_pkg::OP_MUL0: pl_reg <= prod;
            ptps_pkg::OP_MUL1: ph_reg <= prod;
            ptps_pkg::OP_MUL2:
            begin
                dvd_reg <= {ph_reg, 32'd0} + {32'd0, pl_reg};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ptps_pkg::OP_DIV:
            begin
                dvd_reg <= {dvd_reg[ptps_pkg::DVD_W-3:0], 2'b00};
                rem_reg <= rem2;
                quo_reg <= {quo_reg[ptps_pkg::WORD_W-3:0], qb1, qb2};
                cnt_reg <= cnt_reg + ptps_pkg::CNT_W'(1);
            end
            default: cnt_reg <= cnt_reg;
        endcase
    end

    // result word
    logic [ptps_pkg::WORD_W-1:0] q_s, r_s;

    assign q_s = neg_reg ? ptps_pkg::WORD_W'(-quo_reg) : quo_reg;
    assign r_s = neg_reg ? ptps_pkg::WORD_W'(-{1'b0, rem_reg}) : {1'b0, rem_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            is_step <= step_reg;
            if (step_reg)
            begin
                addend_value    <= '0;
                set_seconds     <= q_s;
                set_nanoseconds <= r_s;
            end
            else
            begin
                addend_value    <= base_reg + q_s;
                set_seconds     <= '0;
                set_nanoseconds <= '0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ptp_clock_pi_servo.sv
// ----------------------------------------------------------------------------
// ptp_clock_pi_servo
// proportional-integral servo for a hardware nanosecond clock
// ----------------------------------------------------------------------------
// Each measurement word gives one update word. An offset beyond the step
// threshold yields a step (time split into seconds and nanoseconds, integrator
// cleared); otherwise a slew addend is produced. An update passes through the
// set-up steps PREP1, PREP2, MUL0, MUL1 and MUL2 for the pi terms and two 32x32
// partial products, a two-bit-per-cycle restoring divider over the 96-bit
// product, which is shared with the seconds split, and a final step that loads
// the output register once it is free. No measurement is taken during an
// update; the next one can be accepted in the cycle after that load, and it is
// taken even while a finished update waits on the output.
`default_nettype none

module ptp_clock_pi_servo #(
    parameter int KP_SHIFT         = 2,
    parameter int KI_SHIFT         = 7,
    parameter int INTEGRATOR_LIMIT = 100000
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ptps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ptps_pkg::CFG_DAT_W-1:0] cfg_data,
    ptps_in_if.sink                             meas,
    ptps_out_if.source                          upd
);

    ptps_pkg::dp_cmd_t  cmd;
    ptps_pkg::dp_stat_t stat;

    ptps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (meas.valid),
        .in_ready  (meas.ready),
        .out_valid (upd.valid),
        .out_ready (upd.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptps_dp #(
        .KP_SHIFT         (KP_SHIFT),
        .KI_SHIFT         (KI_SHIFT),
        .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .time_offset     (meas.time_offset),
        .current_time_ns (meas.current_time_ns),
        .cmd             (cmd),
        .stat            (stat),
        .is_step         (upd.is_step),
        .addend_value    (upd.addend_value),
        .set_seconds     (upd.set_seconds),
        .set_nanoseconds (upd.set_nanoseconds)
    );

endmodule

`default_nettype wire

FILE: rtl/ptps_checker.sv
// ----------------------------------------------------------------------------
// ptps_checker
// port-level checks on the servo, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ptps_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        meas_valid,
    input  wire logic                        meas_ready,
    input  wire logic                        upd_valid,
    input  wire logic                        upd_ready,
    input  wire logic                        upd_is_step,
    input  wire logic [ptps_pkg::WORD_W-1:0] upd_addend_value,
    input  wire logic [ptps_pkg::WORD_W-1:0] upd_set_seconds,
    input  wire logic [ptps_pkg::WORD_W-1:0] upd_set_nanoseconds
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && !upd_ready |=> upd_valid)
        else $error("update word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && !upd_ready |=> $stable(upd_addend_value) && $stable(upd_is_step))
        else $error("update word changed while stalled");

    a_step_fields: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && upd_is_step |-> upd_addend_value == '0)
        else $error("step carries an addend");

    a_slew_fields: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && !upd_is_step |-> upd_set_seconds == '0 && upd_set_nanoseconds == '0)
        else $error("slew carries a time");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready |=> !meas_ready)
        else $error("second measurement taken during an update");

endmodule

bind ptp_clock_pi_servo ptps_checker u_ptps_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .meas_valid          (meas.valid),
    .meas_ready          (meas.ready),
    .upd_valid           (upd.valid),
    .upd_ready           (upd.ready),
    .upd_is_step         (upd.is_step),
    .upd_addend_value    (upd.addend_value),
    .upd_set_seconds     (upd.set_seconds),
    .upd_set_nanoseconds (upd.set_nanoseconds)
);

`default_nettype wire
